[rtl/cdzp_pkg.sv]
// Shared constants, types and codes of the zero-padded 1-D convolution layer.
`default_nettype none

package cdzp_pkg;

  localparam int IN_DIM  = 16;
  localparam int OUT_DIM = 16;
  localparam int KSIZE   = 3;

  localparam int WDEPTH = OUT_DIM * KSIZE * IN_DIM;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int CW     = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
  localparam int OW     = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int TW     = (KSIZE > 1) ? $clog2(KSIZE) : 1;

  typedef logic signed [15:0] sample_t;
  typedef logic [IN_DIM-1:0][15:0] frame_t;

  // Per-cell control shared by the whole row
  typedef struct packed {
    logic clear;
    logic rot;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    CMD_WEIGHT = 3'd0,
    CMD_BIAS   = 3'd1,
    CMD_SAMPLE = 3'd2,
    CMD_ZERO   = 3'd3,
    CMD_START  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_KLEN   = 3'd0,
    REG_PAD    = 3'd1,
    REG_IN_CH  = 3'd2,
    REG_OUT_CH = 3'd3,
    REG_BIAS   = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

[rtl/cdzp_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none

module cdzp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/cdzp_cell.sv]
// One history cell: holds a frame, takes its neighbor's frame, rotates samples.
`default_nettype none

module cdzp_cell import cdzp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      take,
  input  wire frame_t    nbr_frame,
  output      frame_t    frame,
  output      sample_t   head
);

  frame_t frame_r;
  frame_t frame_nxt;

  // Clear, load from neighbor, or rotate one sample toward the head
  always_comb begin
    frame_nxt = frame_r;
    priority if (ctl.clear) begin
      frame_nxt = '0;
    end else if (take) begin
      frame_nxt = nbr_frame;
    end else if (ctl.rot) begin
      for (int i = 0; i < IN_DIM - 1; i++) begin
        frame_nxt[i] = frame_r[i+1];
      end
      frame_nxt[IN_DIM-1] = frame_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else begin
      frame_r <= frame_nxt;
    end
  end

  assign frame = frame_r;
  assign head  = sample_t'(frame_r[0]);

endmodule

`default_nettype wire

[rtl/conv1d_zero_pad_layer_top.sv]
// Top level of the stride-1 zero-padded 1-D convolution layer.
`default_nettype none

// Weights go into a single-port RAM, biases into a small register file.
// Frame history is a row of KSIZE cells, newest frame in cell 0; each
// completed frame shifts the row by one cell. A finished window is worked
// through by one multiply-accumulate per cycle while the result output is
// not stalled, all cells rotating their samples past a fixed read point, so
// a window steps through out_channels * kernel_len * IN_DIM products, then
// drains the pipeline. The block takes no new item while a window is in
// progress. A stalled result output freezes the whole multiply-accumulate
// pipeline.
module conv1d_zero_pad_layer_top import cdzp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // command[2:0], index[12:3], sample_value[28:13], bias_value[60:29], zero fill
  input  wire logic [63:0] in_tdata,
  // Result channel
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // out_value[47:0], out_channel[51:48], zero fill
  output      logic [55:0] out_tdata,
  output      logic        out_tlast,
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [4:0]  cfg_wdata
);

  // Input fields
  logic [2:0]         in_command;
  logic [9:0]         in_index;
  sample_t            in_sample_value;
  logic signed [31:0] in_bias_value;
  assign in_command      = in_tdata[2:0];
  assign in_index        = in_tdata[12:3];
  assign in_sample_value = sample_t'(in_tdata[28:13]);
  assign in_bias_value   = in_tdata[60:29];

  // Configuration registers
  logic [1:0] kernel_len_r, zero_padding_r;
  logic [4:0] in_channels_r, out_channels_r;
  logic       bias_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_len_r   <= 2'd3;
      zero_padding_r <= 2'd0;
      in_channels_r  <= 5'd16;
      out_channels_r <= 5'd16;
      bias_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KLEN:   kernel_len_r   <= cfg_wdata[1:0];
        REG_PAD:    zero_padding_r <= cfg_wdata[1:0];
        REG_IN_CH:  in_channels_r  <= cfg_wdata;
        REG_OUT_CH: out_channels_r <= cfg_wdata;
        REG_BIAS:   bias_enable_r  <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // Effective sizes
  logic [1:0] k_eff, pad_eff;
  logic [4:0] nin, nout;
  always_comb begin
    if (kernel_len_r == 2'd0) k_eff = 2'd1;
    else if (32'(kernel_len_r) > KSIZE) k_eff = 2'(KSIZE);
    else k_eff = kernel_len_r;
    pad_eff = (zero_padding_r > k_eff - 2'd1) ? k_eff - 2'd1 : zero_padding_r;
    if (in_channels_r == 5'd0) nin = 5'd1;
    else if (32'(in_channels_r) > IN_DIM) nin = 5'(IN_DIM);
    else nin = in_channels_r;
    if (out_channels_r == 5'd0) nout = 5'd1;
    else if (32'(out_channels_r) > OUT_DIM) nout = 5'(OUT_DIM);
    else nout = out_channels_r;
  end

  // Sequencer and pipeline registers
  state_t state_r, state_nxt;
  logic [CW-1:0]  c_r;
  logic [TW-1:0]  t_r;
  logic [OW-1:0]  o_r;
  logic [WAW-1:0] waddr_r;
  logic [4:0]     fill_r;
  logic [1:0]     held_r;
  logic           s1_v_r, s1_use_r, s1_first_r, s1_end_r;
  logic [OW-1:0]  s1_o_r;
  sample_t        s1_sample_r;
  logic           s2_v_r, s2_use_r, s2_first_r, s2_end_r;
  logic [OW-1:0]  s2_o_r;
  logic signed [31:0] prod_r;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [31:0] bias_r [OUT_DIM];
  logic           out_valid_r, out_last_r;
  logic [47:0]    out_value_r;
  logic [OW-1:0]  out_chan_r;

  logic adv, busy, in_acc, run;
  logic c_last, t_last, o_last, step_use;
  assign adv    = !(out_valid_r && !out_tready);
  assign busy   = (state_r == ST_RUN) || s1_v_r || s2_v_r;
  assign in_tready = !busy;
  assign in_acc = in_tvalid && in_tready;
  assign run    = (state_r == ST_RUN) && adv;
  assign c_last = (c_r == CW'(IN_DIM - 1));
  assign t_last = (t_r == TW'(k_eff - 2'd1));
  assign o_last = (o_r == OW'(nout - 5'd1));
  assign step_use = (5'(c_r) < nin);

  // Frame assembly decode
  logic [4:0] fill_inc;
  logic       is_sample, is_zero, finish, do_start, go_run;
  logic [1:0] held_inc;
  assign is_sample = in_acc && (in_command == CMD_SAMPLE);
  assign is_zero   = in_acc && (in_command == CMD_ZERO);
  assign do_start  = in_acc && (in_command == CMD_START);
  assign fill_inc  = fill_r + 5'd1;
  assign finish    = is_zero || (is_sample && (fill_inc >= nin));
  assign held_inc  = (32'(held_r) < KSIZE) ? held_r + 2'd1 : held_r;
  assign go_run    = finish && (held_inc >= k_eff);

  // Cell row
  frame_t    cell_frame [KSIZE];
  frame_t    cell_nbr   [KSIZE];
  sample_t   cell_head  [KSIZE];
  logic      cell_take  [KSIZE];
  cell_ctl_t ctl;
  frame_t    wr_frame, src_frame;

  assign ctl.clear = do_start;
  assign ctl.rot   = run;

  // Merge the incoming sample into the oldest cell's frame
  always_comb begin
    wr_frame = cell_frame[KSIZE-1];
    if (!fill_r[4]) begin
      wr_frame[fill_r[3:0]] = in_sample_value;
    end
    src_frame = is_zero ? '0 : wr_frame;
  end

  for (genvar j = 0; j < KSIZE; j++) begin : g_cell
    always_comb begin
      if (j == KSIZE - 1 && !finish) begin
        cell_nbr[j] = wr_frame;
      end else if (j == 0) begin
        cell_nbr[j] = src_frame;
      end else begin
        cell_nbr[j] = cell_frame[(j > 0) ? j - 1 : 0];
      end
      cell_take[j] = finish || (j == KSIZE - 1 && is_sample);
    end

    cdzp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .take      (cell_take[j]),
      .nbr_frame (cell_nbr[j]),
      .frame     (cell_frame[j]),
      .head      (cell_head[j])
    );
  end

  // Weight store
  logic           ram_we;
  logic [WAW-1:0] ram_addr;
  logic [15:0]    ram_rdata;
  assign ram_we   = in_acc && (in_command == CMD_WEIGHT) && (32'(in_index) < WDEPTH);
  assign ram_addr = (state_r == ST_RUN) ? waddr_r : WAW'(in_index);

  cdzp_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
    .clk   (clk),
    .we    (ram_we),
    .en    (run),
    .addr  (ram_addr),
    .wdata (in_tdata[28:13]),
    .rdata (ram_rdata)
  );

  // Bias store
  always_ff @(posedge clk) begin
    if (in_acc && (in_command == CMD_BIAS) && (32'(in_index) < OUT_DIM)) begin
      bias_r[OW'(in_index)] <= in_bias_value;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (go_run) state_nxt = ST_RUN;
      ST_RUN:  if (adv && c_last && t_last && o_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Loop counters and frame bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r     <= '0;
      t_r     <= '0;
      o_r     <= '0;
      waddr_r <= '0;
      fill_r  <= '0;
      held_r  <= '0;
    end else begin
      if (go_run) begin
        c_r     <= '0;
        t_r     <= '0;
        o_r     <= '0;
        waddr_r <= '0;
      end else if (run) begin
        c_r <= c_last ? '0 : c_r + CW'(1);
        if (c_last) begin
          t_r <= t_last ? '0 : t_r + TW'(1);
          if (t_last) o_r <= o_r + OW'(1);
        end
        if (step_use) waddr_r <= waddr_r + WAW'(1);
      end
      if (do_start) begin
        fill_r <= '0;
        held_r <= pad_eff;
      end else if (finish) begin
        fill_r <= '0;
        held_r <= held_inc;
      end else if (is_sample) begin
        fill_r <= fill_inc;
      end
    end
  end

  // Multiply-accumulate pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= (state_r == ST_RUN);
      s2_v_r <= s1_v_r;
    end
  end

  // Pipeline payload: fetch, multiply
  logic [TW-1:0] tap_sel;
  assign tap_sel = TW'(k_eff - 2'd1 - 2'(t_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample_r <= cell_head[tap_sel];
      s1_use_r    <= step_use;
      s1_first_r  <= (c_r == '0) && (t_r == '0);
      s1_end_r    <= c_last && t_last;
      s1_o_r      <= o_r;
      prod_r      <= $signed(ram_rdata) * s1_sample_r;
      s2_use_r    <= s1_use_r;
      s2_first_r  <= s1_first_r;
      s2_end_r    <= s1_end_r;
      s2_o_r      <= s1_o_r;
    end
  end

  // Accumulate
  always_comb begin
    logic signed [47:0] base;
    base = s2_first_r ? (bias_enable_r ? 48'(bias_r[s2_o_r]) : 48'sd0) : acc_r;
    acc_nxt = base + (s2_use_r ? 48'(prod_r) : 48'sd0);
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s2_v_r && s2_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r && s2_end_r) begin
      out_value_r <= acc_nxt;
      out_chan_r  <= s2_o_r;
      out_last_r  <= (s2_o_r == OW'(nout - 5'd1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, 4'(out_chan_r), out_value_r};
  assign out_tlast  = out_last_r;

  // Checks
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_v_r && s2_end_r) |=> out_valid_r)
    else $error("finished channel did not reach the output register");

  a_run_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_RUN) |-> (c_r == '0 && t_r == '0 && o_r == '0 && waddr_r == '0))
    else $error("window started with stale loop counters");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("pipeline moved during an output stall");

endmodule

`default_nettype wire
